// ===== rtl/tksc_pkg.sv =====
package tksc_pkg;

	// Slider byte that means no touch
	localparam logic [7:0] NO_TOUCH = 8'h80;
	// Bottom slider value is this minus the raw byte, mod 256
	localparam logic [7:0] LOW_OFFSET = 8'd127;
	localparam logic [7:0] SLIDER_RESET = 8'd127;
	localparam logic [7:0] KEY_RESET = 8'h30;
	localparam logic [6:0] HOLD_LIMIT = 7'd100;
	localparam logic [7:0] BOOT_HOLD_COUNT = 8'd250;
	localparam logic [7:0] BLOCK_TIME_RESET = 8'd25;
	localparam logic [2:0] ALL_KEYS = 3'b111;

	// Key codes swapped by the panel
	localparam logic [7:0] KEY_ONE = 8'h31;
	localparam logic [7:0] KEY_THREE = 8'h33;
	localparam logic [7:0] KEY_FOUR = 8'h34;
	localparam logic [7:0] KEY_SIX = 8'h36;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_KEY_TIME = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PARALLEL_MASK = 1'b1;

	typedef struct packed {
		logic [7:0] low_slider_value;
		logic [7:0] high_slider_value;
		logic       low_slider_new;
		logic       high_slider_new;
		logic [2:0] unit_states;
		logic       red_on;
		logic       green_on;
		logic       bootloader_request;
		logic [6:0] hold_bottom;
		logic [6:0] hold_middle;
		logic [6:0] hold_top;
	} result_t;

	// Undo the panel's swap of '1'/'4' and '3'/'6'
	function automatic logic [7:0] swap_key(input logic [7:0] k);
		logic [7:0] r;
		case (k)
			KEY_ONE:   r = KEY_FOUR;
			KEY_FOUR:  r = KEY_ONE;
			KEY_THREE: r = KEY_SIX;
			KEY_SIX:   r = KEY_THREE;
			default:   r = k;
		endcase
		return r;
	endfunction

	// Apply one key event to the unit on-bits
	function automatic logic [2:0] key_event(input logic [2:0] bits, input logic [2:0] keys,
			input logic [2:0] mask, input logic low_idle, input logic high_idle);
		logic [2:0] s;
		s = bits;
		if (mask == 3'd0) begin
			// serial: top, then middle, then bottom
			if (keys[2]) begin
				if (s[2]) begin
					if (high_idle)
						s = s[0] ? (s & 3'b011) : 3'b000;
				end else begin
					s = s | 3'b110;
				end
			end
			if (keys[1]) begin
				if (s[1]) begin
					if (low_idle && high_idle)
						s = 3'b000;
				end else begin
					s = 3'b111;
				end
			end
			if (keys[0]) begin
				if (s[0]) begin
					if (low_idle)
						s = s[2] ? (s & 3'b110) : 3'b000;
				end else begin
					s = s | 3'b011;
				end
			end
		end else if ((keys & mask) != 3'd0) begin
			if (low_idle && high_idle)
				s = (s != 3'd0) ? 3'b000 : 3'b111;
		end
		return s;
	endfunction

endpackage

// ===== rtl/touch_key_slider_controller_unit.sv =====
// Touch key and slider controller.
// Input channel (in_valid/in_ready) carries one touch-panel report per beat:
// bottom and top slider bytes and the key byte. Output channel
// (out_valid/out_ready) returns exactly one result beat per report: slider
// values and change pulses, unit on-bits, LED levels, bootloader pulse and
// key hold counters.
// The result beat is registered in the output buffer. Throughput: one report per
// cycle while in_ready is high; the state update is a single combinational pass
// between the input handshake and the output register.
// A two-entry output buffer (output register plus skid stage) lets a report be
// taken while a result waits; when the receiver stalls, in_ready drops once
// both entries are full and no result is lost or repeated.
// Configuration (cfg_wr_en, cfg_index, cfg_data) is to be written while idle,
// which the block does not enforce: index 0 is the key block time, index 1 the
// parallel key mask. Reset clears all state to its power-up values and empties
// the output buffer; the block accepts reports as soon as reset is released.
module touch_key_slider_controller_unit
	import tksc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             low_slider_raw,
	input  logic [7:0]             high_slider_raw,
	input  logic [7:0]             key_raw,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             low_slider_value,
	output logic [7:0]             high_slider_value,
	output logic                   low_slider_new,
	output logic                   high_slider_new,
	output logic [2:0]             unit_states,
	output logic [7:0]             red_led,
	output logic [7:0]             green_led,
	output logic [7:0]             blue_led,
	output logic                   bootloader_request,
	output logic [6:0]             hold_bottom,
	output logic [6:0]             hold_middle,
	output logic [6:0]             hold_top
);

	logic    accept;
	result_t result, out_data;

	assign accept = in_valid && in_ready;

	tksc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.step            (accept),
		.low_slider_raw  (low_slider_raw),
		.high_slider_raw (high_slider_raw),
		.key_raw         (key_raw),
		.result          (result)
	);

	tksc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Unpack the result beat onto the ports
	assign low_slider_value = out_data.low_slider_value;
	assign high_slider_value = out_data.high_slider_value;
	assign low_slider_new = out_data.low_slider_new;
	assign high_slider_new = out_data.high_slider_new;
	assign unit_states = out_data.unit_states;
	assign red_led = {8{out_data.red_on}};
	assign green_led = {8{out_data.green_on}};
	assign blue_led = {8{!(out_data.red_on || out_data.green_on)}};
	assign bootloader_request = out_data.bootloader_request;
	assign hold_bottom = out_data.hold_bottom;
	assign hold_middle = out_data.hold_middle;
	assign hold_top = out_data.hold_top;

endmodule

// ===== rtl/tksc_core.sv =====
module tksc_core
	import tksc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic                   step,
	input  logic [7:0]             low_slider_raw,
	input  logic [7:0]             high_slider_raw,
	input  logic [7:0]             key_raw,
	output result_t                result
);

	logic [7:0] block_key_time_q;
	logic [2:0] parallel_key_mask_q;
	logic [7:0] last_low_q, last_high_q;
	logic [7:0] low_value_q, high_value_q;
	logic [7:0] key_code_q;
	logic       red_q, green_q;
	logic [2:0] toggle_q;
	logic [7:0] low_timer_q, high_timer_q;
	logic [7:0] all_keys_q;
	logic [6:0] press_q [3];

	logic       lo_chg, hi_chg, lo_new, hi_new, key_chg, key_new, boot;
	logic [7:0] low_value_d, high_value_d, key_d, all_keys_d;
	logic [7:0] low_timer_d, high_timer_d;
	logic       red_d, green_d;
	logic [2:0] toggle_d;
	logic [6:0] press_d [3];

	// Slider change detect and value load
	always_comb begin
		lo_chg = low_slider_raw != last_low_q;
		hi_chg = high_slider_raw != last_high_q;
		lo_new = lo_chg && (low_slider_raw != NO_TOUCH);
		hi_new = hi_chg && (high_slider_raw != NO_TOUCH);
		low_value_d = lo_new ? (LOW_OFFSET - low_slider_raw) : low_value_q;
		high_value_d = hi_new ? high_slider_raw : high_value_q;
		// top slider wins when both change
		if (hi_chg)
			green_d = hi_new;
		else if (lo_chg)
			green_d = lo_new;
		else
			green_d = green_q;
	end

	// Key code, bootloader detect and hold counters
	always_comb begin
		key_d = swap_key(key_raw);
		key_chg = key_d != key_code_q;
		key_new = key_chg && (key_d[2:0] != 3'd0);
		red_d = key_chg ? key_new : red_q;
		boot = 1'b0;
		all_keys_d = all_keys_q;
		if (key_d[2:0] == ALL_KEYS) begin
			if (all_keys_q < BOOT_HOLD_COUNT) begin
				all_keys_d = all_keys_q + 8'd1;
			end else if (all_keys_q == BOOT_HOLD_COUNT) begin
				all_keys_d = all_keys_q + 8'd1;
				boot = 1'b1;
			end
		end else begin
			all_keys_d = 8'd0;
		end
		for (int i = 0; i < 3; i++) begin
			if (key_d[i])
				press_d[i] = (press_q[i] < HOLD_LIMIT) ? press_q[i] + 7'd1 : press_q[i];
			else
				press_d[i] = 7'd0;
		end
	end

	// Block timers and unit toggling
	always_comb begin
		low_timer_d = lo_new ? block_key_time_q :
			((low_timer_q != 8'd0) ? low_timer_q - 8'd1 : 8'd0);
		high_timer_d = hi_new ? block_key_time_q :
			((high_timer_q != 8'd0) ? high_timer_q - 8'd1 : 8'd0);
		toggle_d = key_new ? key_event(toggle_q, key_d[2:0], parallel_key_mask_q,
			low_timer_d == 8'd0, high_timer_d == 8'd0) : toggle_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_key_time_q <= BLOCK_TIME_RESET;
			parallel_key_mask_q <= 3'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BLOCK_KEY_TIME: block_key_time_q <= cfg_data;
				CFG_PARALLEL_MASK:  parallel_key_mask_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Advance state on each accepted report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_low_q <= 8'd0;
			last_high_q <= 8'd0;
			low_value_q <= SLIDER_RESET;
			high_value_q <= SLIDER_RESET;
			key_code_q <= KEY_RESET;
			red_q <= 1'b0;
			green_q <= 1'b0;
			toggle_q <= 3'd0;
			low_timer_q <= 8'd0;
			high_timer_q <= 8'd0;
			all_keys_q <= 8'd0;
			for (int i = 0; i < 3; i++)
				press_q[i] <= 7'd0;
		end else if (step) begin
			last_low_q <= low_slider_raw;
			last_high_q <= high_slider_raw;
			low_value_q <= low_value_d;
			high_value_q <= high_value_d;
			key_code_q <= key_d;
			red_q <= red_d;
			green_q <= green_d;
			toggle_q <= toggle_d;
			low_timer_q <= low_timer_d;
			high_timer_q <= high_timer_d;
			all_keys_q <= all_keys_d;
			for (int i = 0; i < 3; i++)
				press_q[i] <= press_d[i];
		end
	end

	// Gather the result beat
	always_comb begin
		result.low_slider_value = low_value_d;
		result.high_slider_value = high_value_d;
		result.low_slider_new = lo_new;
		result.high_slider_new = hi_new;
		result.unit_states = toggle_d;
		result.red_on = red_d;
		result.green_on = green_d;
		result.bootloader_request = boot;
		result.hold_bottom = press_d[0];
		result.hold_middle = press_d[1];
		result.hold_top = press_d[2];
	end

endmodule

// ===== rtl/tksc_outbuf.sv =====
module tksc_outbuf
	import tksc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t main_q, skid_q;
	logic    main_v_q, skid_v_q;
	logic    pop;

	assign pop = main_v_q && out_ready;
	assign space = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data = main_q;

	// Track occupancy of the output and skid stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				main_v_q <= push || skid_v_q;
				skid_v_q <= 1'b0;
			end else if (push) begin
				main_v_q <= 1'b1;
				skid_v_q <= main_v_q;
			end
		end
	end

	// Move beats: new beat to the free stage, skid drains into output
	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			if (main_v_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule
